[src/xcrf_pkg.sv]
// shared types and opcode constants for the x86 code reference finder
package xcrf_pkg;

  // positions evaluated in one window and bytes held between transfers
  localparam int unsigned WIN_LEN  = 7;
  localparam int unsigned HOLD_LEN = 6;

  // opcodes of interest
  localparam logic [7:0] OP_MOV_EAX    = 8'hB8;
  localparam logic [7:0] OP_MOV_ECX    = 8'hB9;
  localparam logic [7:0] OP_MOV_EDX    = 8'hBA;
  localparam logic [7:0] OP_PUSH_IMM   = 8'h68;
  localparam logic [7:0] OP_MOV_RM_IMM = 8'hC7;
  localparam logic [7:0] OP_REX_W      = 8'h48;
  localparam logic [7:0] OP_CALL_REL   = 8'hE8;
  localparam logic [7:0] OP_LEA        = 8'h8D;
  localparam logic [7:0] OP_CALL_FAR   = 8'h9A;

  // configuration register indexes
  localparam logic [1:0] CFG_TARGET = 2'd0;
  localparam logic [1:0] CFG_LEGACY = 2'd1;
  localparam logic [1:0] CFG_MODE   = 2'd2;

  // match kinds
  localparam logic MATCH_ABS = 1'b0;
  localparam logic MATCH_REL = 1'b1;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [63:0] byte_address;
    logic        region_end;
  } in_t;

  typedef struct packed {
    logic [63:0] match_address;
    logic        match_kind;
    logic        run_last;
  } out_t;

  typedef struct packed {
    logic [63:0] target_address;
    logic        legacy_32bit;
    logic        scan_mode;
  } cfg_t;

  // one window ready for evaluation
  typedef struct packed {
    logic [WIN_LEN-1:0][7:0] bytes;
    logic [2:0]              count;
    logic [63:0]             first_address;
    logic [WIN_LEN-1:0]      lane_en;
  } eval_t;

endpackage

[src/xcrf_window.sv]
// byte window and input register feeding the position checkers
module xcrf_window (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  xcrf_pkg::in_t   in_data,
  input  logic            load_ready,
  output logic            eval_valid,
  output xcrf_pkg::eval_t eval_data
);

  logic [xcrf_pkg::HOLD_LEN-1:0][7:0] win_r, win_nxt;
  logic [2:0]                         fill_r, fill_nxt;
  logic                               eval_valid_r, eval_valid_nxt;
  xcrf_pkg::eval_t                    eval_r, eval_nxt;
  logic                               in_fire;
  logic [xcrf_pkg::WIN_LEN-1:0][7:0]  buf_w;
  logic [2:0]                         cnt_w;

  // accept while the input register is empty or being drained
  assign in_ready = !eval_valid_r || load_ready;
  assign in_fire  = in_valid && in_ready;

  // held bytes with the new byte placed after them
  always_comb begin
    for (int i = 0; i < xcrf_pkg::HOLD_LEN; i++) begin
      buf_w[i] = (fill_r == 3'(i)) ? in_data.data_byte : win_r[i];
    end
    buf_w[xcrf_pkg::HOLD_LEN] = in_data.data_byte;
    cnt_w = fill_r + 3'd1;
  end

  // window update: flush at region end, slide once full
  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    if (in_fire) begin
      if (in_data.region_end) begin
        fill_nxt = 3'd0;
      end else if (cnt_w == 3'(xcrf_pkg::WIN_LEN)) begin
        for (int i = 0; i < xcrf_pkg::HOLD_LEN; i++) begin
          win_nxt[i] = buf_w[i+1];
        end
        fill_nxt = 3'(xcrf_pkg::HOLD_LEN);
      end else begin
        win_nxt  = buf_w[xcrf_pkg::HOLD_LEN-1:0];
        fill_nxt = cnt_w;
      end
    end
  end

  // which positions get examined for this byte
  always_comb begin
    eval_nxt.bytes         = buf_w;
    eval_nxt.count         = cnt_w;
    eval_nxt.first_address = in_data.byte_address - 64'(fill_r);
    for (int k = 0; k < xcrf_pkg::WIN_LEN; k++) begin
      if (in_data.region_end) begin
        eval_nxt.lane_en[k] = (3'(k) < cnt_w);
      end else begin
        eval_nxt.lane_en[k] = (k == 0) && (cnt_w == 3'(xcrf_pkg::WIN_LEN));
      end
    end
    eval_valid_nxt = in_fire ? 1'b1 : (load_ready ? 1'b0 : eval_valid_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= 3'd0;
      eval_valid_r <= 1'b0;
    end else begin
      fill_r       <= fill_nxt;
      eval_valid_r <= eval_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (in_fire) begin
      eval_r <= eval_nxt;
    end
  end

  assign eval_valid = eval_valid_r;
  assign eval_data  = eval_r;

endmodule

[src/xcrf_lane.sv]
// opcode check for one byte position of the window
module xcrf_lane (
  input  logic                              en,
  input  logic [xcrf_pkg::WIN_LEN-1:0][7:0] bytes,
  input  logic [2:0]                        avail,
  input  logic [63:0]                       pos_address,
  input  xcrf_pkg::cfg_t                    cfg,
  output logic                              hit,
  output logic                              kind
);

  logic [7:0]  op;
  logic [31:0] imm1, imm3, disp;
  logic [63:0] rel_sum;
  logic        rel_eq, abs1_eq, abs3_eq, has5, has7, hit_w;

  // little-endian operands at +1 and +3
  assign op   = bytes[0];
  assign imm1 = {bytes[4], bytes[3], bytes[2], bytes[1]};
  assign imm3 = {bytes[6], bytes[5], bytes[4], bytes[3]};
  assign disp = (op == xcrf_pkg::OP_CALL_REL) ? imm1 : imm3;

  // relative target: next instruction address plus sign-extended displacement
  assign rel_sum = pos_address + ((op == xcrf_pkg::OP_CALL_REL) ? 64'd5 : 64'd7)
                   + {{32{disp[31]}}, disp};
  assign rel_eq  = (rel_sum == cfg.target_address);
  assign abs1_eq = (imm1 == cfg.target_address[31:0]);
  assign abs3_eq = (imm3 == cfg.target_address[31:0]);
  assign has5    = (avail >= 3'd5);
  assign has7    = (avail == 3'd7);

  // decode by scan mode
  always_comb begin
    hit_w = 1'b0;
    kind  = xcrf_pkg::MATCH_ABS;
    if (!cfg.scan_mode) begin
      unique case (op)
        xcrf_pkg::OP_MOV_EAX, xcrf_pkg::OP_MOV_ECX,
        xcrf_pkg::OP_MOV_EDX, xcrf_pkg::OP_PUSH_IMM: begin
          hit_w = cfg.legacy_32bit && has5 && abs1_eq;
        end
        xcrf_pkg::OP_MOV_RM_IMM: begin
          hit_w = cfg.legacy_32bit && has7 && abs3_eq;
        end
        xcrf_pkg::OP_REX_W: begin
          hit_w = !cfg.legacy_32bit && has7 && rel_eq;
          kind  = xcrf_pkg::MATCH_REL;
        end
        default: begin
          hit_w = 1'b0;
        end
      endcase
    end else begin
      unique case (op)
        xcrf_pkg::OP_CALL_REL: begin
          hit_w = has5 && rel_eq;
          kind  = xcrf_pkg::MATCH_REL;
        end
        xcrf_pkg::OP_REX_W: begin
          hit_w = !cfg.legacy_32bit && has7 && (bytes[1] == xcrf_pkg::OP_LEA) && rel_eq;
          kind  = xcrf_pkg::MATCH_REL;
        end
        xcrf_pkg::OP_PUSH_IMM, xcrf_pkg::OP_CALL_FAR: begin
          hit_w = cfg.legacy_32bit && has5 && abs1_eq;
        end
        default: begin
          hit_w = 1'b0;
        end
      endcase
    end
  end

  assign hit = en && hit_w;

endmodule

[src/xcrf_drain.sv]
// match mask register and output register, one match per transfer
module xcrf_drain (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         eval_valid,
  input  logic [63:0]                  eval_base,
  input  logic [xcrf_pkg::WIN_LEN-1:0] hits,
  input  logic [xcrf_pkg::WIN_LEN-1:0] kinds,
  output logic                         load_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output xcrf_pkg::out_t               out_data
);

  logic [xcrf_pkg::WIN_LEN-1:0] mask_r, mask_nxt, kind_r, mask_rest;
  logic [63:0]                  base_r;
  xcrf_pkg::out_t               out_r, out_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_free, pop, load, is_last;
  logic [2:0]                   low_idx;

  // lowest pending position goes first
  always_comb begin
    low_idx = 3'd0;
    for (int k = xcrf_pkg::WIN_LEN - 1; k >= 0; k--) begin
      if (mask_r[k]) begin
        low_idx = 3'(k);
      end
    end
  end

  // pending positions once the lowest one is gone
  assign mask_rest = mask_r & (mask_r - {{(xcrf_pkg::WIN_LEN-1){1'b0}}, 1'b1});

  // handshake between mask register and output register
  assign out_free   = !out_valid_r || out_ready;
  assign is_last    = (mask_r != '0) && (mask_rest == '0);
  assign pop        = (mask_r != '0) && out_free;
  assign load_ready = (mask_r == '0) || (is_last && out_free);
  assign load       = eval_valid && load_ready;

  // next values
  always_comb begin
    out_nxt.match_address = base_r + 64'(low_idx);
    out_nxt.match_kind    = kind_r[low_idx];
    out_nxt.run_last      = is_last;
    if (load) begin
      mask_nxt = hits;
    end else if (pop) begin
      mask_nxt = mask_rest;
    end else begin
      mask_nxt = mask_r;
    end
    out_valid_nxt = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      base_r <= eval_base;
      kind_r <= kinds;
    end
    if (pop) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/x86_code_reference_finder.sv]
// top level of the x86 code reference finder
//
// Bytes of a memory region stream in on the in_ channel (valid/ready), one
// per transfer, each with its address and a flag on the last byte of the
// region. Every byte position is checked as an x86 opcode against the
// target set through the cfg_ write port; matching positions leave on the
// out_ channel (valid/ready) in address order, run_last marking the final
// match caused by one input byte. Configure only while the block is idle.
// A position is checked once six further bytes have arrived, or when the
// region ends, at which point all held positions are checked at once.
// The first match of a byte passes through the input register, the mask
// register and the output register; further matches follow without a gap
// while out_ready holds. Throughput: one byte per cycle while the receiver
// accepts, as long as no byte causes more than one match; a byte causing m
// matches holds the input while the output register drains them, which sets the rate.
// Reset empties the window and the pipeline and clears the configuration to zero.
// When the receiver stalls, the output register holds its match, the mask
// register fills behind it, and in_ready then drops.
module x86_code_reference_finder (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  xcrf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output xcrf_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [63:0]    cfg_wdata
);

  xcrf_pkg::cfg_t               cfg_r;
  logic                         eval_valid, load_ready;
  xcrf_pkg::eval_t              eval_data;
  logic [12:0][7:0]             pad_w;
  logic [xcrf_pkg::WIN_LEN-1:0] hits, kinds;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        xcrf_pkg::CFG_TARGET: cfg_r.target_address <= cfg_wdata;
        xcrf_pkg::CFG_LEGACY: cfg_r.legacy_32bit   <= cfg_wdata[0];
        xcrf_pkg::CFG_MODE:   cfg_r.scan_mode      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  xcrf_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .load_ready (load_ready),
    .eval_valid (eval_valid),
    .eval_data  (eval_data)
  );

  // bytes past the window read as zero; lanes gate them by availability
  assign pad_w = {48'h0, eval_data.bytes};

  // one checker per window position
  for (genvar k = 0; k < xcrf_pkg::WIN_LEN; k++) begin : g_lane
    xcrf_lane u_lane (
      .en          (eval_data.lane_en[k]),
      .bytes       (pad_w[k+6:k]),
      .avail       (eval_data.count - 3'(k)),
      .pos_address (eval_data.first_address + 64'(k)),
      .cfg         (cfg_r),
      .hit         (hits[k]),
      .kind        (kinds[k])
    );
  end

  xcrf_drain u_drain (
    .clk        (clk),
    .rst_n      (rst_n),
    .eval_valid (eval_valid),
    .eval_base  (eval_data.first_address),
    .hits       (hits),
    .kinds      (kinds),
    .load_ready (load_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[src/xcrf_checker.sv]
// port-level checks for the x86 code reference finder, bound to the top level
module xcrf_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input xcrf_pkg::out_t out_data
);

  // a stalled match holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled match changed");

  // the output register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("match present right after reset");

  // the input side is open right after reset
  a_reset_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_ready)
    else $error("input blocked right after reset");

  // more matches of the same byte follow without a gap
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.run_last |=> out_valid)
    else $error("gap inside a run of matches");

  // matches of one run are at distinct positions
  a_run_advances: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.run_last |=>
      out_data.match_address != $past(out_data.match_address))
    else $error("repeated position inside a run");

endmodule

bind x86_code_reference_finder xcrf_checker u_xcrf_checker (.*);

[bench/match_board_pkg.sv]
// scoreboard class that predicts and checks the matches of the x86 code reference finder
package match_board_pkg;
  import xcrf_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  class match_board;
    // copy of the configuration registers
    logic [63:0] target;
    logic        legacy;
    logic        mode;

    // bytes of the current region not yet examined
    logic [7:0]  held[HOLD_LEN];
    int unsigned held_cnt;
    logic [7:0]  win[16];

    out_t        pending_matches[$];
    int unsigned errors;
    int unsigned matches_expected;
    int unsigned matches_checked;

    function new();
      target = '0;
      legacy = 1'b0;
      mode = 1'b0;
      held_cnt = 0;
      errors = 0;
      matches_expected = 0;
      matches_checked = 0;
      foreach (held[i]) held[i] = '0;
      foreach (win[i]) win[i] = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] value);
      case (idx)
        CFG_TARGET: target = value;
        CFG_LEGACY: legacy = value[0];
        CFG_MODE:   mode = value[0];
        default: ;
      endcase
    endfunction

    // little-endian 32-bit field of the window
    function logic [31:0] imm32(int unsigned o);
      return {win[o+3], win[o+2], win[o+1], win[o]};
    endfunction

    function logic [63:0] widen(logic [31:0] d);
      return {{32{d[31]}}, d};
    endfunction

    // does the instruction starting at window slot k reference the target
    function bit finds_reference(int unsigned k, int unsigned avail, logic [63:0] addr,
                                 output logic kind);
      logic [7:0]  op;
      logic [31:0] lo;
      op = win[k];
      lo = target[31:0];
      kind = MATCH_ABS;
      if (!mode) begin
        if (op inside {OP_MOV_EAX, OP_MOV_ECX, OP_MOV_EDX, OP_PUSH_IMM}) begin
          if (legacy && avail >= 5 && imm32(k + 1) == lo) return 1'b1;
        end else if (op == OP_MOV_RM_IMM) begin
          if (legacy && avail >= 7 && imm32(k + 3) == lo) return 1'b1;
        end else if (op == OP_REX_W) begin
          kind = MATCH_REL;
          if (!legacy && avail >= 7 && addr + 64'd7 + widen(imm32(k + 3)) == target)
            return 1'b1;
        end
      end else begin
        if (op == OP_CALL_REL) begin
          kind = MATCH_REL;
          if (avail >= 5 && addr + 64'd5 + widen(imm32(k + 1)) == target) return 1'b1;
        end else if (op == OP_REX_W) begin
          kind = MATCH_REL;
          if (!legacy && avail >= 7 && win[k+1] == OP_LEA &&
              addr + 64'd7 + widen(imm32(k + 3)) == target) return 1'b1;
        end else if (op == OP_PUSH_IMM || op == OP_CALL_FAR) begin
          if (legacy && avail >= 5 && imm32(k + 1) == lo) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // accepted input byte: examine the positions it completes
    function void note_byte(in_t item);
      out_t        found[$];
      out_t        m;
      int unsigned n;
      int unsigned last;
      logic        kind;
      for (int unsigned k = 0; k < held_cnt; k++) win[k] = held[k];
      win[held_cnt] = item.data_byte;
      n = held_cnt + 1;
      if (item.region_end) last = n;
      else if (n == WIN_LEN) last = 1;
      else last = 0;
      for (int unsigned k = 0; k < last; k++) begin
        m.match_address = item.byte_address - 64'(n - 1 - k);
        m.run_last = 1'b0;
        if (finds_reference(k, n - k, m.match_address, kind)) begin
          m.match_kind = kind;
          found = {found, m};
        end
      end
      if (found.size() > 0) found[found.size() - 1].run_last = 1'b1;
      foreach (found[i]) pending_matches = {pending_matches, found[i]};
      matches_expected += found.size();
      // slide or flush the window
      if (item.region_end) begin
        held_cnt = 0;
      end else if (n == WIN_LEN) begin
        for (int unsigned k = 0; k < HOLD_LEN; k++) held[k] = win[k+1];
        held_cnt = HOLD_LEN;
      end else begin
        for (int unsigned k = 0; k < n; k++) held[k] = win[k];
        held_cnt = n;
      end
    endfunction

    // accepted result: compare with the oldest prediction
    function void check_match(out_t got);
      out_t want;
      matches_checked++;
      if (pending_matches.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected match: addr %h kind %b last %b",
                   got.match_address, got.match_kind, got.run_last);
        return;
      end
      want = pending_matches.pop_front();
      if (got.match_address !== want.match_address || got.match_kind !== want.match_kind ||
          got.run_last !== want.run_last) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("mismatch: expected addr %h kind %b last %b, got addr %h kind %b last %b",
                   want.match_address, want.match_kind, want.run_last,
                   got.match_address, got.match_kind, got.run_last);
      end
    endfunction
  endclass

endpackage

[bench/tb.sv]
// testbench top for the x86 code reference finder
module tb;
  import xcrf_pkg::*;
  import match_board_pkg::*;

  localparam logic [1:0]  CFG_UNUSED         = 2'd3;
  localparam int unsigned CYCLE_LIMIT        = 400000;
  localparam int unsigned HOLD_CYCLES        = 300;
  localparam int unsigned SETTLE_CYCLES      = 10;
  localparam int unsigned RANDOM_BYTES       = 70;
  localparam int unsigned MAX_PHASES         = 60;

  localparam logic [7:0] ABS_OPS[4] = '{OP_MOV_EAX, OP_MOV_ECX, OP_MOV_EDX, OP_PUSH_IMM};
  localparam logic [7:0] KNOWN_OPS[9] = '{OP_MOV_EAX, OP_MOV_ECX, OP_MOV_EDX, OP_PUSH_IMM,
                                          OP_MOV_RM_IMM, OP_REX_W, OP_CALL_REL, OP_LEA,
                                          OP_CALL_FAR};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_TARGET;
  logic [63:0] cfg_wdata = '0;

  match_board  board = new();

  // current register values, used to build matching instructions
  logic [63:0] cur_target = '0;
  logic        cur_legacy = 1'b0;
  logic        cur_mode = 1'b0;

  logic [7:0]  region_bytes[$];
  int unsigned bytes_sent = 0;
  int unsigned regions_sent = 0;
  int unsigned configs_written = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_done = 0;
  int unsigned cycle_count = 0;

  x86_code_reference_finder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // write all registers; only called while the block is idle
  task automatic write_config(input logic [63:0] target, input logic legacy, input logic mode);
    logic [63:0] junk;
    junk = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
    cfg_we <= 1'b1;
    cfg_index <= CFG_TARGET;
    cfg_wdata <= target;
    @(posedge clk);
    board.set_reg(CFG_TARGET, target);
    cfg_index <= CFG_LEGACY;
    cfg_wdata <= {junk[63:1], legacy};
    @(posedge clk);
    board.set_reg(CFG_LEGACY, {junk[63:1], legacy});
    cfg_index <= CFG_MODE;
    cfg_wdata <= {junk[63:1], mode};
    @(posedge clk);
    board.set_reg(CFG_MODE, {junk[63:1], mode});
    // an index with no register behind it must change nothing
    if ($urandom_range(0, 2) == 0) begin
      cfg_index <= CFG_UNUSED;
      cfg_wdata <= ~target;
      @(posedge clk);
      board.set_reg(CFG_UNUSED, ~target);
    end
    cfg_we <= 1'b0;
    cur_target = target;
    cur_legacy = legacy;
    cur_mode = mode;
    configs_written++;
  endtask

  // one input transfer, after a random gap unless tight
  task automatic send_byte(input in_t item, input bit tight);
    int unsigned gap;
    gap = (tight || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    board.note_byte(item);
    bytes_sent++;
  endtask

  // send region_bytes as one region, optionally with jumps in the addresses
  task automatic send_region(input logic [63:0] base, input bit tight, input bit jumps);
    in_t         item;
    logic [63:0] skew;
    skew = '0;
    foreach (region_bytes[i]) begin
      if (jumps && $urandom_range(0, 24) == 0) skew = skew + {$urandom, $urandom};
      item.data_byte = region_bytes[i];
      item.byte_address = base + 64'(i) + skew;
      item.region_end = (i == region_bytes.size() - 1);
      send_byte(item, tight);
    end
    regions_sent++;
  endtask

  // stop offering, wait for every predicted match and let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // append one byte to the region under construction
  task automatic add_byte(input logic [7:0] b);
    region_bytes.insert(region_bytes.size(), b);
  endtask

  task automatic add_le32(input logic [31:0] v);
    add_byte(v[7:0]);
    add_byte(v[15:8]);
    add_byte(v[23:16]);
    add_byte(v[31:24]);
  endtask

  // append an instruction that references the target, or a near miss when spoiled
  task automatic add_reference(input logic [63:0] base, input bit spoil);
    logic [63:0] at;
    logic [63:0] disp;
    int unsigned idx;
    at = base + 64'(region_bytes.size());
    if (!cur_mode) begin
      if (cur_legacy) begin
        if ($urandom_range(0, 4) == 4) begin
          add_byte(OP_MOV_RM_IMM);
          add_byte(8'($urandom));
          add_byte(8'($urandom));
        end else begin
          add_byte(ABS_OPS[$urandom_range(0, 3)]);
        end
        add_le32(cur_target[31:0]);
      end else begin
        add_byte(OP_REX_W);
        add_byte(8'($urandom));
        add_byte(8'($urandom));
        disp = cur_target - (at + 64'd7);
        add_le32(disp[31:0]);
      end
    end else if ($urandom_range(0, 1)) begin
      add_byte(OP_CALL_REL);
      disp = cur_target - (at + 64'd5);
      add_le32(disp[31:0]);
    end else if (!cur_legacy) begin
      add_byte(OP_REX_W);
      add_byte(OP_LEA);
      add_byte(8'($urandom));
      disp = cur_target - (at + 64'd7);
      add_le32(disp[31:0]);
    end else begin
      add_byte($urandom_range(0, 1) ? OP_PUSH_IMM : OP_CALL_FAR);
      add_le32(cur_target[31:0]);
    end
    if (spoil) begin
      idx = region_bytes.size() - 1 - $urandom_range(0, 3);
      region_bytes[idx] = region_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 3))
      add_byte($urandom_range(0, 1) ? KNOWN_OPS[$urandom_range(0, 8)] : 8'($urandom));
  endtask

  // random region: mostly references with random content, some noise and near misses
  task automatic build_region(input logic [63:0] base);
    int unsigned pick;
    region_bytes.delete();
    repeat ($urandom_range(1, 4)) begin
      pick = $urandom_range(0, 9);
      if (pick <= 4) add_reference(base, 1'b0);
      else if (pick <= 6) add_reference(base, 1'b1);
      else add_noise();
    end
    // instruction cut short by the region end
    if ($urandom_range(0, 3) == 0) begin
      add_reference(base, 1'b0);
      repeat ($urandom_range(1, 3)) void'(region_bytes.pop_back());
    end
  endtask

  function automatic logic [63:0] pick_base();
    logic [31:0] r;
    case ($urandom_range(0, 5))
      0: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 30));
      1: return 64'($urandom_range(0, 30));
      default: begin
        r = $urandom;
        if (!cur_legacy || cur_mode) return cur_target + {{40{r[23]}}, r[23:0]};
        return {$urandom, $urandom};
      end
    endcase
  endfunction

  // result side: random stalls, calm stretches and the long hold-off
  initial begin
    int unsigned pause;
    int unsigned calm;
    calm = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_requested > holds_done) begin
        pause = HOLD_CYCLES;
        holds_done++;
      end else if (calm > 0) begin
        pause = 0;
        calm--;
      end else begin
        if ($urandom_range(0, 15) == 0) calm = $urandom_range(5, 30);
        pause = $urandom_range(0, 1) ? 0 : $urandom_range(0, 19);
      end
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_match(out_data);
    end
  end

  // stimulus
  initial begin
    int unsigned phase;
    int unsigned random_bytes_start;
    logic [63:0] target;
    logic [63:0] base;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // absolute immediates: mov reg and mov r/m forms, then a push cut off by the region end
    write_config(64'hFFFF_FFFF_1234_5678, 1'b1, 1'b0);
    region_bytes = '{OP_MOV_EAX, 8'h78, 8'h56, 8'h34, 8'h12,
                     OP_MOV_RM_IMM, 8'h05, 8'h00, 8'h78, 8'h56, 8'h34, 8'h12};
    send_region(64'h0, 1'b0, 1'b0);
    region_bytes = '{OP_PUSH_IMM, 8'h78, 8'h56, 8'h34};
    send_region(64'h0000_0000_0040_1000, 1'b0, 1'b0);
    drain();

    // relative call and lea whose sums wrap past the top of the address space
    write_config(64'h0, 1'b0, 1'b1);
    region_bytes = '{OP_CALL_REL, 8'h0B, 8'h00, 8'h00, 8'h00,
                     OP_REX_W, OP_LEA, 8'h05, 8'h04, 8'h00, 8'h00, 8'h00};
    send_region(64'hFFFF_FFFF_FFFF_FFF0, 1'b1, 1'b0);
    drain();

    // back-to-back push opcodes, all but the last four of which match, while the result side holds off
    write_config({$urandom, 32'h6868_6868}, 1'b1, 1'b1);
    region_bytes.delete();
    repeat (24) add_byte(OP_PUSH_IMM);
    holds_requested++;
    send_region({$urandom, $urandom}, 1'b1, 1'b0);
    drain();

    // random phases over the register settings
    random_bytes_start = bytes_sent;
    phase = 0;
    while (bytes_sent - random_bytes_start < RANDOM_BYTES && phase < MAX_PHASES) begin
      if (phase == 0) target = '0;
      else if (phase == 1) target = '1;
      else target = {$urandom, $urandom};
      write_config(target, phase[0], phase[1]);
      repeat ($urandom_range(1, 3)) begin
        base = pick_base();
        build_region(base);
        send_region(base, $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0);
      end
      drain();
      phase++;
    end

    $display("%0d bytes in %0d regions over %0d register settings, %0d matches checked",
             bytes_sent, regions_sent, configs_written, board.matches_checked);
    if (board.errors == 0 && board.pending_matches.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
